FILE: design/cls_pkg.sv
package cls_pkg;

    localparam int LIST_DEPTH_DEF = 64;
    localparam int KEY_W          = 32;
    localparam int OP_W           = 2;
    localparam int REPORT_W       = 7;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 24;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [REPORT_W-1:0] NO_INDEX = 7'h7F;

    // per-cell control from the list controller
    typedef struct packed {
        logic live;    // cell lies below the fill count
        logic load;    // write the request key into this cell
        logic shift;   // take the entry of the next cell up
    } cls_cell_ctrl_t;

endpackage

FILE: design/cls_cell.sv
module cls_cell (
    input  logic                         clk,
    input  cls_pkg::cls_cell_ctrl_t      ctrl,
    input  logic [cls_pkg::KEY_W-1:0]    key,
    input  logic [cls_pkg::KEY_W-1:0]    nbr_entry,
    output logic [cls_pkg::KEY_W-1:0]    entry,
    output logic                         match
);
    import cls_pkg::*;

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    logic             match_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            entry_next = key;
        end
        else if (ctrl.shift)
        begin
            entry_next = nbr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= ctrl.live && (entry_reg == key);
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

FILE: design/cls_find.sv
module cls_find #(
    parameter int LIST_DEPTH = cls_pkg::LIST_DEPTH_DEF,
    parameter int LEVELS     = $clog2(LIST_DEPTH),
    parameter int IW         = (LEVELS > 0) ? LEVELS : 1
) (
    input  logic                  clk,
    input  logic [LIST_DEPTH-1:0] match,
    output logic                  hit,
    output logic [IW-1:0]         pos
);
    import cls_pkg::*;

    localparam int P = 1 << LEVELS;

    logic [P-1:0]                    match_pad;
    logic [LEVELS:0][P-1:0]          any_reg;
    logic [LEVELS:0][P-1:0][IW-1:0]  idx_reg;

    assign match_pad = P'(match);

    // registered priority tree, lower half of each pair wins
    always_ff @(posedge clk)
    begin
        for (int n = 0; n < P; n++)
        begin
            any_reg[0][n] <= match_pad[n];
            idx_reg[0][n] <= '0;
        end
        for (int l = 1; l <= LEVELS; l++)
        begin
            for (int n = 0; n < P / 2; n++)
            begin
                any_reg[l][n] <= any_reg[l-1][2*n] | any_reg[l-1][2*n+1];
                idx_reg[l][n] <= any_reg[l-1][2*n] ? idx_reg[l-1][2*n]
                               : (idx_reg[l-1][2*n+1] | (IW'(1) << (l - 1)));
            end
        end
    end

    assign hit = any_reg[LEVELS][0];
    assign pos = idx_reg[LEVELS][0];

endmodule

FILE: design/compacting_list_store.sv
// compacting list store: bounded list of signed 32-bit keys kept in arrival order
//
// requests arrive on the s_ channel, one beat per request: opcode insert appends,
// search reports the first equal entry, remove deletes the first equal entry and
// closes the gap by shifting every later cell down one place, all in the same update.
// each request gives exactly one result beat on the m_ channel.
//
// the entries sit in a row of cells; every cell compares its entry with the key
// and the match bits go through a registered priority tree of log2(LIST_DEPTH)
// levels. one request is in work at a time: search and remove pass through the
// cell compare, the tree leaves and the tree levels before the update that loads
// the result register; insert and the unused opcode go straight to the update.
// the next request is accepted in the cycle after the update, while the previous
// result may still be waiting in the output register; if the receiver stalls,
// that next request waits before its update until the output register is taken.
//
// reset empties the list (fill count zero); stored entries are not cleared and
// need no clearing pass.
module compacting_list_store #(
    parameter int LIST_DEPTH = cls_pkg::LIST_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // opcode[1:0], key[33:2], zero fill
    input  logic [cls_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // ok[0], found_index[7:1], count[14:8], is_empty[15], is_full[16], zero fill
    output logic [cls_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import cls_pkg::*;

    localparam int LEVELS = $clog2(LIST_DEPTH);
    localparam int IW     = (LEVELS > 0) ? LEVELS : 1;
    localparam int CW     = $clog2(LIST_DEPTH + 1);
    localparam int WW     = $clog2(LEVELS + 2) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_APPLY
    } state_t;

    state_t                  state_reg;
    logic [OP_W-1:0]         op_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [WW-1:0]           wait_reg;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic [LIST_DEPTH-1:0]   match;
    logic [KEY_W-1:0]        entry [LIST_DEPTH];
    cls_cell_ctrl_t          ctrl  [LIST_DEPTH];
    logic                    hit;
    logic [IW-1:0]           pos;

    logic                    in_take;
    logic                    commit;
    logic                    ins_ok;
    logic                    rem_ok;
    logic                    lookup;
    logic                    ok;
    logic [REPORT_W-1:0]     found_field;
    logic [IW+REPORT_W-1:0]  pos_wide;
    logic [CW+REPORT_W-1:0]  count_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign in_take  = s_tvalid && s_tready;
    assign commit   = (state_reg == S_APPLY) && (!out_valid_reg || m_tready);

    assign lookup = (op_reg == OP_SEARCH) || (op_reg == OP_REMOVE);
    assign ins_ok = (op_reg == OP_INSERT) && (count_reg < CW'(LIST_DEPTH));
    assign rem_ok = (op_reg == OP_REMOVE) && hit;
    assign ok     = ins_ok || (lookup && hit);

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    assign pos_wide    = {{REPORT_W{1'b0}}, pos};
    assign count_wide  = {{REPORT_W{1'b0}}, count_next};
    assign found_field = (lookup && hit) ? pos_wide[REPORT_W-1:0] : NO_INDEX;

    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic [KEY_W-1:0] nbr;

        if (i == LIST_DEPTH - 1)
        begin : g_top
            assign nbr = entry[i];
        end
        else
        begin : g_mid
            assign nbr = entry[i+1];
        end

        assign ctrl[i].live  = (CW'(i) < count_reg);
        assign ctrl[i].load  = commit && ins_ok && (count_reg == CW'(i));
        assign ctrl[i].shift = commit && rem_ok && (IW'(i) >= pos);

        cls_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .key       (key_reg),
            .nbr_entry (nbr),
            .entry     (entry[i]),
            .match     (match[i])
        );
    end

    cls_find #(
        .LIST_DEPTH (LIST_DEPTH),
        .LEVELS     (LEVELS),
        .IW         (IW)
    ) u_find (
        .clk   (clk),
        .match (match),
        .hit   (hit),
        .pos   (pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !commit)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_take)
                    begin
                        wait_reg <= '0;
                        if ((s_tdata[1:0] == OP_SEARCH) || (s_tdata[1:0] == OP_REMOVE))
                        begin
                            state_reg <= S_SEARCH;
                        end
                        else
                        begin
                            state_reg <= S_APPLY;
                        end
                    end
                end
                S_SEARCH:
                begin
                    // cell compare, tree leaves, then each tree level in turn
                    wait_reg <= wait_reg + WW'(1);
                    if (wait_reg == WW'(LEVELS + 1))
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    if (commit)
                    begin
                        count_reg     <= count_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg  <= s_tdata[1:0];
            key_reg <= s_tdata[33:2];
        end
        if (commit)
        begin
            out_data_reg <= OUT_TDATA_W'({count_next == CW'(LIST_DEPTH),
                                          count_next == '0,
                                          count_wide[REPORT_W-1:0],
                                          found_field,
                                          ok});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(LIST_DEPTH))
        else $error("fill count beyond list depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && ins_ok) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not grow the list");

    a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY && lookup && hit) |-> (CW'(pos) < count_reg))
        else $error("match found beyond the filled part of the list");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |=> !commit || $past(wait_reg) == WW'(LEVELS + 1)
                                    || (state_reg == S_APPLY))
        else $error("list updated while the search was still in flight");

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cls_pkg::*;

    localparam int DEPTH        = LIST_DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 20;
    localparam int NUM_DIRECTED = 25;

    // no meaning in the block, answered as a miss
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
    localparam logic [KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic                ok;
        logic [REPORT_W-1:0] found_index;
        logic [REPORT_W-1:0] count;
        logic                is_empty;
        logic                is_full;
    } list_report_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic             typed;
        list_report_t     report;
    } request_row_t;

    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

    localparam list_report_t NO_CHECK   = '0;
    localparam list_report_t EMPTY_MISS = '{1'b0, NO_INDEX, 7'd0, 1'b1, 1'b0};

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [KEY_W-1:0] shadow_list [$];
    list_report_t     awaited_reports [$];
    request_row_t     directed_rows [NUM_DIRECTED];

    bit steady;
    int fails;
    int cycles;
    int requests_sent;
    int beats_checked;
    int inserts_done;
    int inserts_refused;
    int key_hits;
    int key_misses;
    int unused_ops;
    int times_full;

    compacting_list_store dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        m_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // shadow copy of the list: returns the report one request produces
    function automatic list_report_t list_update(input logic [OP_W-1:0] op,
                                                 input logic [KEY_W-1:0] key);
        list_report_t res;
        int           pos;
        res = '{1'b0, NO_INDEX, 7'd0, 1'b0, 1'b0};
        pos = -1;
        if (op == OP_INSERT)
        begin
            if (shadow_list.size() < DEPTH)
            begin
                shadow_list.push_back(key);
                res.ok = 1'b1;
                inserts_done++;
                if (shadow_list.size() == DEPTH)
                    times_full++;
            end
            else
                inserts_refused++;
        end
        else if (op == OP_SEARCH || op == OP_REMOVE)
        begin
            foreach (shadow_list[i])
                if (pos < 0 && shadow_list[i] == key)
                    pos = i;
            if (pos >= 0)
            begin
                res.ok          = 1'b1;
                res.found_index = REPORT_W'(pos);
                key_hits++;
                if (op == OP_REMOVE)
                    shadow_list.delete(pos);
            end
            else
                key_misses++;
        end
        else
            unused_ops++;
        res.count    = REPORT_W'(shadow_list.size());
        res.is_empty = (shadow_list.size() == 0);
        res.is_full  = (shadow_list.size() == DEPTH);
        return res;
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return KEY_W'($urandom_range(0, 7));
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return KEY_MIN;
                    1: return KEY_MAX;
                    2: return '1;
                    default: return '0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [KEY_W-1:0] stored_key();
        if (shadow_list.size() == 0)
            return pick_key();
        return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        list_report_t got;
        list_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{m_tdata[0], m_tdata[7:1], m_tdata[14:8], m_tdata[15], m_tdata[16]};
            if (awaited_reports.size() == 0)
            begin
                $error("result beat with no request outstanding: %h", m_tdata);
                fails++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                check_field("ok", 32'(want.ok), 32'(got.ok));
                check_field("found_index", 32'(want.found_index), 32'(got.found_index));
                check_field("count", 32'(want.count), 32'(got.count));
                check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
                check_field("is_full", 32'(want.is_full), 32'(got.is_full));
                beats_checked++;
            end
            check_field("zero fill", '0, 32'(m_tdata[OUT_TDATA_W-1:17]));
        end
    end

    // leaves time at the edge where the beat was taken
    task automatic send_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                                input logic typed, input list_report_t typed_report);
        list_report_t predicted;
        steady = (requests_sent >= 500 && requests_sent < 750);
        while (!steady && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - KEY_W - OP_W){1'b0}}, key, op};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = list_update(op, key);
        awaited_reports.push_back(typed ? typed_report : predicted);
        requests_sent++;
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_reports.size() != 0);
    endtask

    initial
    begin
        phase_t phase;
        int     r;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        steady   = 1'b0;

        directed_rows = '{
            '{OP_SEARCH, 32'h0, 1'b1, EMPTY_MISS},
            '{OP_REMOVE, 32'h0, 1'b1, EMPTY_MISS},
            '{OP_UNUSED, 32'h0, 1'b1, EMPTY_MISS},
            '{OP_INSERT, KEY_MIN, 1'b1, '{1'b1, NO_INDEX, 7'd1, 1'b0, 1'b0}},
            '{OP_INSERT, KEY_MAX, 1'b1, '{1'b1, NO_INDEX, 7'd2, 1'b0, 1'b0}},
            '{OP_INSERT, 32'h0, 1'b0, NO_CHECK},
            '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, NO_CHECK},
            '{OP_INSERT, 32'd5, 1'b0, NO_CHECK},
            '{OP_INSERT, 32'd5, 1'b0, NO_CHECK},
            '{OP_INSERT, 32'h5555_5555, 1'b0, NO_CHECK},
            '{OP_INSERT, 32'hAAAA_AAAA, 1'b0, NO_CHECK},
            '{OP_SEARCH, KEY_MIN, 1'b1, '{1'b1, 7'd0, 7'd8, 1'b0, 1'b0}},
            '{OP_SEARCH, 32'd5, 1'b0, NO_CHECK},
            '{OP_SEARCH, 32'd6, 1'b1, '{1'b0, NO_INDEX, 7'd8, 1'b0, 1'b0}},
            '{OP_UNUSED, 32'd5, 1'b1, '{1'b0, NO_INDEX, 7'd8, 1'b0, 1'b0}},
            '{OP_REMOVE, 32'd5, 1'b0, NO_CHECK},
            '{OP_SEARCH, 32'd5, 1'b0, NO_CHECK},
            '{OP_REMOVE, KEY_MIN, 1'b0, NO_CHECK},
            '{OP_REMOVE, 32'hAAAA_AAAA, 1'b0, NO_CHECK},
            '{OP_REMOVE, 32'd12345, 1'b0, NO_CHECK},
            '{OP_REMOVE, KEY_MAX, 1'b0, NO_CHECK},
            '{OP_REMOVE, 32'hFFFF_FFFF, 1'b0, NO_CHECK},
            '{OP_REMOVE, 32'h0, 1'b0, NO_CHECK},
            '{OP_REMOVE, 32'h5555_5555, 1'b0, NO_CHECK},
            '{OP_REMOVE, 32'd5, 1'b1, '{1'b1, 7'd0, 7'd0, 1'b1, 1'b0}}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].key,
                         directed_rows[i].typed, directed_rows[i].report);
        wait_all_results();

        while (requests_sent < NUM_DIRECTED + RANDOM_ITEMS)
        begin
            phase = phase_t'($urandom_range(0, 2));
            if ($urandom_range(0, 2) == 0)
                wait_all_results();
            case (phase)
                PH_FILL:
                begin
                    while (shadow_list.size() < DEPTH)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 85)
                            send_request(OP_INSERT, pick_key(), 1'b0, NO_CHECK);
                        else if (r < 92)
                            send_request(OP_SEARCH, stored_key(), 1'b0, NO_CHECK);
                        else if (r < 97)
                            send_request(OP_REMOVE, pick_key(), 1'b0, NO_CHECK);
                        else
                            send_request(OP_UNUSED, $urandom(), 1'b0, NO_CHECK);
                    end
                    // a full list refuses inserts; the last cell must still be found
                    repeat ($urandom_range(1, 4))
                        send_request(OP_INSERT, pick_key(), 1'b0, NO_CHECK);
                    send_request(OP_SEARCH, shadow_list[DEPTH-1], 1'b0, NO_CHECK);
                    send_request(OP_SEARCH, stored_key(), 1'b0, NO_CHECK);
                end
                PH_DRAIN:
                begin
                    while (shadow_list.size() != 0)
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 80)
                            send_request(OP_REMOVE, stored_key(), 1'b0, NO_CHECK);
                        else if (r < 90)
                            send_request(OP_SEARCH, r[0] ? stored_key() : pick_key(),
                                         1'b0, NO_CHECK);
                        else if (r < 95)
                            send_request(OP_REMOVE, pick_key(), 1'b0, NO_CHECK);
                        else
                            send_request(OP_INSERT, pick_key(), 1'b0, NO_CHECK);
                    end
                    repeat ($urandom_range(1, 3))
                        send_request($urandom_range(0, 1) ? OP_REMOVE : OP_SEARCH,
                                     pick_key(), 1'b0, NO_CHECK);
                end
                default:
                begin
                    repeat ($urandom_range(20, 60))
                    begin
                        r = $urandom_range(0, 99);
                        if (r < 35)
                            send_request(OP_INSERT, pick_key(), 1'b0, NO_CHECK);
                        else if (r < 65)
                            send_request(OP_SEARCH, r[0] ? stored_key() : pick_key(),
                                         1'b0, NO_CHECK);
                        else if (r < 95)
                            send_request(OP_REMOVE, r[0] ? stored_key() : pick_key(),
                                         1'b0, NO_CHECK);
                        else
                            send_request(OP_UNUSED, $urandom(), 1'b0, NO_CHECK);
                    end
                end
            endcase
        end

        wait_all_results();
        repeat (SETTLE) @(posedge clk);

        $display("%0d requests, %0d result beats checked; list filled to %0d entries %0d times",
                 requests_sent, beats_checked, DEPTH, times_full);
        $display("inserts %0d (%0d refused when full), key hits %0d, misses %0d, unused %0d",
                 inserts_done, inserts_refused, key_hits, key_misses, unused_ops);
        if (fails == 0 && awaited_reports.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
